// ----- hdl/lbg_pkg.sv -----
package lbg_pkg;

	// scan and frame geometry
	localparam int SLOT_W     = 4;
	localparam int DIGIT_W    = 3;
	localparam int BYTE_W     = 8;
	localparam int BAR_DIGITS = 5;
	localparam int BAR_W      = BAR_DIGITS * BYTE_W;
	localparam int ROWS       = 2;
	localparam int ROW_AW     = 1;
	localparam int PHASE_W    = 4;

	localparam logic [BYTE_W-1:0]  BAR_MAX    = 8'd40;
	localparam logic [PHASE_W-1:0] PHASE_WRAP = 4'd10;
	localparam logic [BYTE_W-1:0]  BLINK_WRAP = 8'd10;
	localparam logic [BYTE_W-1:0]  BLINK_HALF = 8'd5;

	// digit codes
	localparam logic [DIGIT_W-1:0] ALARM_DIGIT = 3'd5;
	localparam logic [DIGIT_W-1:0] BLANK_DIGIT = 3'd6;

	// frame phases that do work
	localparam logic [PHASE_W-1:0] PH_BAR   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_ALARM = 4'd2;
	localparam logic [PHASE_W-1:0] PH_BLINK = 4'd3;

	// frame memory rows: bar digits 0..4 in one row, alarm byte in the other
	localparam logic [ROW_AW-1:0] ROW_BAR   = 1'b0;
	localparam logic [ROW_AW-1:0] ROW_ALARM = 1'b1;

	// write request from the frame sequencer
	typedef struct packed {
		logic              we;
		logic [ROW_AW-1:0] row;
		logic [BAR_W-1:0]  data;
	} frame_wr_t;

	// one-hot LED for a marker position, 0 lights nothing
	function automatic logic [BAR_W-1:0] mark_mask(input logic [BYTE_W-1:0] pos);
		logic [BYTE_W-1:0] p;
		logic [BAR_W-1:0]  m;
		p = (pos > BAR_MAX) ? BAR_MAX : pos;
		m = '0;
		if (p != '0) begin
			m = BAR_W'(1) << (p - 8'd1);
		end
		return m;
	endfunction

endpackage

// ----- hdl/lbg_ram.sv -----
module lbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/lbg_seq.sv -----
module lbg_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            bar_level,
	input  logic [7:0]            high_mark,
	input  logic [7:0]            low_mark,
	input  logic [7:0]            mean_mark,
	input  logic [7:0]            alarm_pattern,
	input  logic                  blink_enable,
	output lbg_pkg::frame_wr_t    wr
);
	import lbg_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_nx;
	logic [BYTE_W-1:0]  blink_cnt_q;
	logic [BYTE_W-1:0]  blink_cnt_inc;
	logic               blink_off_q;
	logic [BYTE_W-1:0]  level;
	logic [BAR_W-1:0]   bar;
	logic [BAR_W-1:0]   hl_mask;
	logic [BAR_W-1:0]   frame_bar;

	assign phase_nx      = phase_q + PHASE_W'(1);
	assign blink_cnt_inc = blink_cnt_q + BYTE_W'(1);

	// bar fill: positions 1..level lit
	always_comb begin
		level = (bar_level > BAR_MAX) ? BAR_MAX : bar_level;
		for (int i = 0; i < BAR_W; i++) begin
			bar[i] = (BYTE_W'(i) < level);
		end
		hl_mask   = mark_mask(high_mark) | mark_mask(low_mark);
		frame_bar = blink_off_q ? (bar & ~hl_mask) : (bar | hl_mask);
		frame_bar = frame_bar | mark_mask(mean_mark);
	end

	// frame write on the blank-slot tick
	always_comb begin
		wr.we   = 1'b0;
		wr.row  = ROW_BAR;
		wr.data = frame_bar;
		if (step && phase_nx == PH_BAR) begin
			wr.we = 1'b1;
		end else if (step && phase_nx == PH_ALARM) begin
			wr.we   = 1'b1;
			wr.row  = ROW_ALARM;
			wr.data = BAR_W'(alarm_pattern);
		end
	end

	// phase counter and blink state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			blink_cnt_q <= '0;
			blink_off_q <= 1'b1;
		end else if (step) begin
			phase_q <= (phase_nx >= PHASE_WRAP) ? '0 : phase_nx;
			if (phase_nx == PH_BLINK) begin
				if (blink_enable) begin
					if (blink_cnt_inc >= BLINK_WRAP) begin
						blink_cnt_q <= '0;
						blink_off_q <= 1'b1;
					end else begin
						blink_cnt_q <= blink_cnt_inc;
						blink_off_q <= (blink_cnt_inc < BLINK_HALF);
					end
				end else begin
					blink_cnt_q <= blink_cnt_inc;
					blink_off_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- hdl/led_bar_graph_display_scanner.sv -----
// Channel  Handshake             Payload
// in       in_valid / in_ready   bar_level, high_mark, low_mark, mean_mark,
//                                alarm_pattern, blink_enable
// out      out_valid / out_ready digit_on, segment_drive
//
// One item per cycle sustained while out_ready stays high; an accepted item goes
// through stage one (frame memory read at accept), then the output register.
// The frame memory read issued at accept is bypassed when the previous item
// writes the same row in that cycle.
// Reset clears scan slot, phase, blink count and row valid bits; unwritten rows read
// as all ones. No clearing pass.
// A stalled output holds the item in stage one and drops in_ready.
module led_bar_graph_display_scanner #(
	parameter int SCAN_LAST = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] bar_level,
	input  logic [7:0] high_mark,
	input  logic [7:0] low_mark,
	input  logic [7:0] mean_mark,
	input  logic [7:0] alarm_pattern,
	input  logic       blink_enable,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] digit_on,
	output logic [7:0] segment_drive
);
	import lbg_pkg::*;

	logic                in_acc;
	logic                s1_go;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W:0]     slot_inc;
	logic [ROW_AW-1:0]   rd_row;
	logic                s1_valid_q;
	logic [SLOT_W-1:0]   slot_s1;
	logic [7:0]          bar_level_s1;
	logic [7:0]          high_mark_s1;
	logic [7:0]          low_mark_s1;
	logic [7:0]          mean_mark_s1;
	logic [7:0]          alarm_pattern_s1;
	logic                blink_enable_s1;
	logic                row_ok_s1;
	logic                fwd_hit_s1;
	logic [ROWS-1:0]     row_valid_q;
	logic [BAR_W-1:0]    fwd_q;
	logic [BAR_W-1:0]    rdata;
	logic [BAR_W-1:0]    row_s1;
	logic [BYTE_W-1:0]   digit_byte;
	logic [BYTE_W-1:0]   hold_q;
	logic                is_digit;
	frame_wr_t           wr;

	assign in_acc   = in_valid && in_ready;
	assign s1_go    = s1_valid_q && (!out_valid || out_ready);
	assign in_ready = !s1_valid_q || s1_go;
	assign slot_inc = {1'b0, slot_q} + (SLOT_W+1)'(1);
	assign rd_row   = (slot_q[DIGIT_W-1:0] == ALARM_DIGIT && slot_q[SLOT_W-1] == 1'b0)
	                  ? ROW_ALARM : ROW_BAR;

	lbg_ram #(.WIDTH(BAR_W), .DEPTH(ROWS)) u_frame (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.row),
		.wdata (wr.data),
		.re    (in_acc),
		.raddr (rd_row),
		.rdata (rdata)
	);

	lbg_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (s1_go && slot_s1 == SLOT_W'(BLANK_DIGIT)),
		.bar_level     (bar_level_s1),
		.high_mark     (high_mark_s1),
		.low_mark      (low_mark_s1),
		.mean_mark     (mean_mark_s1),
		.alarm_pattern (alarm_pattern_s1),
		.blink_enable  (blink_enable_s1),
		.wr            (wr)
	);

	// scan slot counter, stage-one and output valid, row valid bits and hold byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			s1_valid_q  <= 1'b0;
			row_valid_q <= '0;
			out_valid   <= 1'b0;
			hold_q      <= '0;
		end else begin
			if (in_acc) begin
				slot_q <= (slot_inc > (SLOT_W+1)'(SCAN_LAST)) ? '0 : slot_inc[SLOT_W-1:0];
			end
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (wr.we) begin
				row_valid_q[wr.row] <= 1'b1;
			end
			if (s1_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (s1_go && is_digit) begin
				hold_q <= ~digit_byte;
			end
		end
	end

	// stage-one payload, row status and write bypass
	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_s1          <= slot_q;
			bar_level_s1     <= bar_level;
			high_mark_s1     <= high_mark;
			low_mark_s1      <= low_mark;
			mean_mark_s1     <= mean_mark;
			alarm_pattern_s1 <= alarm_pattern;
			blink_enable_s1  <= blink_enable;
			row_ok_s1        <= row_valid_q[rd_row];
			fwd_hit_s1       <= wr.we && wr.row == rd_row;
		end
		if (wr.we) begin
			fwd_q <= wr.data;
		end
	end

	// pick the row source and the digit byte out of the row
	always_comb begin
		if (fwd_hit_s1) begin
			row_s1 = fwd_q;
		end else if (row_ok_s1) begin
			row_s1 = rdata;
		end else begin
			row_s1 = '1;
		end
		is_digit = (slot_s1 < SLOT_W'(ALARM_DIGIT) + SLOT_W'(1));
		if (slot_s1 == SLOT_W'(ALARM_DIGIT)) begin
			digit_byte = row_s1[BYTE_W-1:0];
		end else begin
			digit_byte = row_s1[slot_s1[DIGIT_W-1:0]*BYTE_W +: BYTE_W];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_go) begin
			digit_on      <= is_digit ? slot_s1[DIGIT_W-1:0] : BLANK_DIGIT;
			segment_drive <= is_digit ? ~digit_byte : hold_q;
		end
	end

endmodule
